/* rtl/assert_macros.svh */
// Assertion macros used by the checker of the keyboard report builder.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while the asynchronous reset is asserted.
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/krb_pkg.sv */
// Package of the keyboard report builder: beat types, mode codes and default sizes.
// No dependencies; imported by every module of the block but krb_ram.
`timescale 1ns / 1ps

package krb_pkg;

	localparam int KRB_NUM_KEYS     = 32;
	localparam int KRB_REPORT_SLOTS = 6;
	localparam int OUT_SLOTS        = 6;
	localparam int CODE_W           = 8;
	localparam int COUNT_W          = 3;
	localparam int INDEX_W          = 5;
	localparam int PRESS_BIT        = 7;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_SCAN = 1'b1;

	typedef struct packed {
		logic               mode;
		logic [INDEX_W-1:0] key_index;
		logic [7:0]         key_sample;
		logic [CODE_W-1:0]  map_code;
		logic               map_is_modifier;
		logic               last_key;
	} key_beat_t;

	typedef struct packed {
		logic [CODE_W-1:0]  slot_zero;
		logic [CODE_W-1:0]  slot_one;
		logic [CODE_W-1:0]  slot_two;
		logic [CODE_W-1:0]  slot_three;
		logic [CODE_W-1:0]  slot_four;
		logic [CODE_W-1:0]  slot_five;
		logic [CODE_W-1:0]  modifier_bits;
		logic [COUNT_W-1:0] used_slots;
	} report_t;

	// Keymap lookup result handed from the keymap stage to the scan stage.
	typedef struct packed {
		logic              vld;
		logic              last;
		logic              hit;
		logic              is_mod;
		logic [CODE_W-1:0] code;
	} lookup_t;

endpackage

/* rtl/keyboard_report_builder.sv */
// Top level of the keyboard report builder: keymap stage plus scan stage.
// Depends on krb_pkg, krb_keymap and krb_scan.
`timescale 1ns / 1ps

// The keyboard report builder takes one beat per clock on the key channel.
// A load beat (mode zero) writes one keymap entry, a code and a modifier
// flag; a scan beat (mode one) presents one key's detect byte, and a pressed
// key either ORs its code into the modifier byte or appends its code to the
// next of REPORT_SLOTS report slots. The scan beat marked as the last key
// produces one report beat through the first-stage registers and the report
// register, then the scan state clears. The keymap sits in a RAM with a
// registered read: the first stage reads the entry, the second updates the
// slot registers and loads the report register. Throughput is one beat per cycle;
// the key channel stalls only when a last-key beat reaches the second stage
// while the previous report still waits on the report channel. Keymap codes
// are not cleared by reset; the modifier flags are, through a written bit per
// entry, so no clearing pass runs after reset and beats are taken at once.
module keyboard_report_builder #(
	parameter int NUM_KEYS     = krb_pkg::KRB_NUM_KEYS,
	parameter int REPORT_SLOTS = krb_pkg::KRB_REPORT_SLOTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               key_valid,
	output logic               key_ready,
	input  krb_pkg::key_beat_t key_beat,
	output logic               rpt_valid,
	input  logic               rpt_ready,
	output krb_pkg::report_t   rpt
);
	import krb_pkg::*;

	lookup_t look;
	logic    stall;
	logic    accept;

	// The only back pressure comes from a report that cannot leave yet.
	assign key_ready = !stall;
	assign accept    = key_valid && key_ready;

	krb_keymap #(
		.NUM_KEYS(NUM_KEYS)
	) u_keymap (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.beat  (key_beat),
		.stall (stall),
		.look  (look)
	);

	krb_scan #(
		.REPORT_SLOTS(REPORT_SLOTS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.look     (look),
		.rpt_ready(rpt_ready),
		.stall    (stall),
		.rpt_valid(rpt_valid),
		.rpt      (rpt)
	);

endmodule

/* rtl/krb_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module krb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/krb_keymap.sv */
// Keymap stage: keymap RAM, per-entry written bits and the first pipeline stage.
// Depends on krb_pkg and krb_ram.
`timescale 1ns / 1ps

module krb_keymap #(
	parameter int NUM_KEYS = krb_pkg::KRB_NUM_KEYS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  krb_pkg::key_beat_t beat,
	input  logic               stall,
	output krb_pkg::lookup_t   look
);
	import krb_pkg::*;

	localparam int AW = $clog2(NUM_KEYS);
	localparam int IW = (AW > INDEX_W) ? AW : INDEX_W;
	localparam int CW = ($clog2(NUM_KEYS + 1) > INDEX_W) ? $clog2(NUM_KEYS + 1) : INDEX_W;

	logic [IW-1:0]       idx_w;
	logic [AW-1:0]       addr;
	logic                in_range;
	logic                is_scan;
	logic                wr_en;
	logic [CODE_W:0]     rdata;
	logic [NUM_KEYS-1:0] written_q;

	logic vld_s1;
	logic last_s1;
	logic hit_s1;
	logic written_s1;

	assign idx_w    = IW'(beat.key_index);
	assign addr     = idx_w[AW-1:0];
	assign in_range = CW'(beat.key_index) < CW'(NUM_KEYS);
	assign is_scan  = beat.mode == MODE_SCAN;
	assign wr_en    = accept && !is_scan && in_range;

	// Entry layout: modifier flag above the code.
	krb_ram #(
		.WIDTH(CODE_W + 1),
		.DEPTH(NUM_KEYS)
	) u_map_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(addr),
		.wdata({beat.map_is_modifier, beat.map_code}),
		.re   (accept),
		.raddr(addr),
		.rdata(rdata)
	);

	// An entry never written reads as a plain key, so its flag is masked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			vld_s1    <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[addr] <= 1'b1;
			end
			if (!stall) begin
				vld_s1 <= accept && is_scan;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			last_s1    <= beat.last_key;
			hit_s1     <= in_range && beat.key_sample[PRESS_BIT];
			written_s1 <= in_range && written_q[addr];
		end
	end

	assign look.vld    = vld_s1;
	assign look.last   = last_s1;
	assign look.hit    = hit_s1;
	assign look.is_mod = written_s1 && rdata[CODE_W];
	assign look.code   = rdata[CODE_W-1:0];

endmodule

/* rtl/krb_scan.sv */
// Scan stage: slot and modifier accumulation and the registered report output.
// Depends on krb_pkg.
`timescale 1ns / 1ps

module krb_scan #(
	parameter int REPORT_SLOTS = krb_pkg::KRB_REPORT_SLOTS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  krb_pkg::lookup_t look,
	input  logic             rpt_ready,
	output logic             stall,
	output logic             rpt_valid,
	output krb_pkg::report_t rpt
);
	import krb_pkg::*;

	localparam logic [COUNT_W-1:0] CAP = COUNT_W'(REPORT_SLOTS);

	logic [CODE_W-1:0]  slot_q [OUT_SLOTS];
	logic [CODE_W-1:0]  slot_n [OUT_SLOTS];
	logic [CODE_W-1:0]  gated  [OUT_SLOTS];
	logic [COUNT_W-1:0] count_q, count_n;
	logic [CODE_W-1:0]  mod_q, mod_n;
	logic               stopped_q, stopped_n;
	logic               rpt_valid_q;
	report_t            rpt_q;
	logic               advance;

	assign stall   = look.vld && look.last && rpt_valid_q && !rpt_ready;
	assign advance = look.vld && !stall;

	always_comb begin
		slot_n    = slot_q;
		count_n   = count_q;
		mod_n     = mod_q;
		stopped_n = stopped_q;
		if (look.hit && !stopped_q) begin
			if (look.is_mod) begin
				mod_n = mod_q | look.code;
			end else if (count_q >= CAP) begin
				// Report is full: ignore the rest of this scan.
				stopped_n = 1'b1;
			end else if (look.code != '0) begin
				for (int j = 0; j < OUT_SLOTS; j++) begin
					if (COUNT_W'(j) == count_q) begin
						slot_n[j] = look.code;
					end
				end
				count_n = count_q + 1'b1;
			end
		end
		for (int j = 0; j < OUT_SLOTS; j++) begin
			gated[j] = (COUNT_W'(j) < count_n) ? slot_n[j] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			mod_q       <= '0;
			stopped_q   <= 1'b0;
			rpt_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				if (look.last) begin
					count_q   <= '0;
					mod_q     <= '0;
					stopped_q <= 1'b0;
				end else begin
					count_q   <= count_n;
					mod_q     <= mod_n;
					stopped_q <= stopped_n;
				end
			end
			if (advance && look.last) begin
				rpt_valid_q <= 1'b1;
			end else if (rpt_ready) begin
				rpt_valid_q <= 1'b0;
			end
		end
	end

	// Slots past the fill count are masked on output, so they need no clear.
	always_ff @(posedge clk) begin
		if (advance) begin
			slot_q <= slot_n;
		end
		if (advance && look.last) begin
			rpt_q.slot_zero     <= gated[0];
			rpt_q.slot_one      <= gated[1];
			rpt_q.slot_two      <= gated[2];
			rpt_q.slot_three    <= gated[3];
			rpt_q.slot_four     <= gated[4];
			rpt_q.slot_five     <= gated[5];
			rpt_q.modifier_bits <= mod_n;
			rpt_q.used_slots    <= count_n;
		end
	end

	assign rpt_valid = rpt_valid_q;
	assign rpt       = rpt_q;

endmodule

/* rtl/krb_checker.sv */
// Port-level checker for the keyboard report builder, bound to the top level.
// Depends on krb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module krb_checker #(
	parameter int REPORT_SLOTS = krb_pkg::KRB_REPORT_SLOTS
) (
	input logic               clk,
	input logic               arst_n,
	input logic               key_valid,
	input logic               key_ready,
	input krb_pkg::key_beat_t key_beat,
	input logic               rpt_valid,
	input logic               rpt_ready,
	input krb_pkg::report_t   rpt
);
	import krb_pkg::*;

	logic last_scan_acc;

	assign last_scan_acc = key_valid && key_ready && key_beat.mode == MODE_SCAN &&
		key_beat.last_key;

	// A waiting report stays up until it is taken.
	`ASSERT_CLKD(a_rpt_hold, clk, arst_n, rpt_valid && !rpt_ready |=> rpt_valid, "report dropped")

	// A new report must follow an accepted last-key scan beat.
	`ASSERT_CLKD(a_rpt_cause, clk, arst_n, $rose(rpt_valid) |-> $past(last_scan_acc, 2), "report without last key")

	// The fill count never passes the slot capacity.
	`ASSERT_CLKD(a_rpt_count, clk, arst_n, rpt_valid |-> rpt.used_slots <= COUNT_W'(REPORT_SLOTS), "slot count too high")

	// Slots zero and five read as zero when unused.
	`ASSERT_CLKD(a_rpt_zero, clk, arst_n, rpt_valid |-> (rpt.used_slots >= 3'd1 || rpt.slot_zero == 8'd0) && (rpt.used_slots >= 3'd6 || rpt.slot_five == 8'd0), "unused slot not zero")

endmodule

bind keyboard_report_builder krb_checker #(
	.REPORT_SLOTS(REPORT_SLOTS)
) u_krb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.key_valid(key_valid),
	.key_ready(key_ready),
	.key_beat (key_beat),
	.rpt_valid(rpt_valid),
	.rpt_ready(rpt_ready),
	.rpt      (rpt)
);
